[sv/hla_pkg.sv]
// Shared constants, types and trig table of the Hough line accumulator.
package hla_pkg;

  localparam int ANGLES      = 180;
  localparam int RHO         = 256;
  localparam int COUNT_BITS  = 16;
  localparam int PEAK_WINDOW = 18;

  localparam int CELLS     = RHO * ANGLES;
  localparam int ANG_W     = $clog2(ANGLES);
  localparam int RHO_W     = $clog2(RHO);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int PEAK_H    = PEAK_WINDOW / 2;
  localparam int PEAK_SPAN = 2 * PEAK_H;
  localparam int SPAN_W    = $clog2(PEAK_SPAN);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    ACT_VOTE  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } hla_action_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_EDGE_THRESHOLD = 3'd2,
    CFG_BORDER_MARGIN  = 3'd3,
    CFG_RHO_OFFSET     = 3'd4,
    CFG_RHO_SCALE      = 3'd5
  } hla_cfg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VCHECK,
    ST_VOTE,
    ST_VDRAIN,
    ST_QREAD,
    ST_QLATCH,
    ST_QDECIDE,
    ST_SCAN,
    ST_SDRAIN,
    ST_DIV,
    ST_DWAIT,
    ST_OUT
  } hla_state_e;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic vote_issue;
    logic q_read;
    logic q_latch;
    logic scan_init;
    logic scan_issue;
    logic div_start;
    logic out_load;
  } hla_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic vote_ok;
    logic vote_last;
    logic pipe_busy;
    logic peak_cand;
    logic scan_last;
    logic div_done;
    logic out_free;
  } hla_status_t;

  typedef logic signed [15:0] hla_rom_t [ANGLES];

  // shift-subtract long division, only used while building the tables
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q30 Taylor series, rounded to Q14
  function automatic logic signed [15:0] series_q14(logic [63:0] x, logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] n;
    logic [63:0] den;
    logic signed [63:0] sum;
    logic [63:0] rnd;
    int k;
    x2   = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    sum  = $signed(term);
    n    = odd ? 64'd1 : 64'd0;
    for (k = 1; k < 12; k++) begin
      term = (term * x2) >> 30;
      den  = (n + 64'd1) * (n + 64'd2);
      term = udiv64(term, den);
      n    = n + 64'd2;
      if ((k & 1) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    rnd = ($unsigned(sum) + 64'd32768) >> 16;
    return $signed(rnd[15:0]);
  endfunction

  function automatic hla_rom_t build_trig(logic want_sin);
    hla_rom_t rom;
    logic [63:0] j;
    logic [63:0] th;
    logic signed [15:0] c;
    logic mirror;
    int i;
    for (i = 0; i < ANGLES; i++) begin
      mirror = (2 * i > ANGLES);
      j      = mirror ? 64'(ANGLES - i) : 64'(i);
      th     = udiv64(j * PI_Q30, 64'(ANGLES));
      c      = series_q14(th, 1'b0);
      if (want_sin) rom[i] = series_q14(th, 1'b1);
      else rom[i] = mirror ? -c : c;
    end
    return rom;
  endfunction

  localparam hla_rom_t COS_ROM = build_trig(1'b0);
  localparam hla_rom_t SIN_ROM = build_trig(1'b1);

endpackage

[sv/hla_divider.sv]
// Restoring divider, one quotient bit per cycle, for the intensity ratio.
module hla_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [23:0] quotient_o,
  output logic        done_o
);

  logic [16:0] rem_q, rem_d;
  logic [23:0] quo_q, quo_d;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q[15:0], quo_q[23]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[22:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[sv/hla_datapath.sv]
// Datapath: config, accumulator memory, rho pipeline, window scan, result register.
module hla_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hla_pkg::hla_cmd_t                   cmd_i,
  output hla_pkg::hla_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [hla_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [hla_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [11:0]                         pixel_x_i,
  input  logic [11:0]                         pixel_y_i,
  input  logic [7:0]                          edge_strength_i,
  input  logic [7:0]                          rho_index_i,
  input  logic [7:0]                          angle_index_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [15:0]                         cell_count_o,
  output logic [7:0]                          intensity_o,
  output logic                                is_peak_o,
  output logic [15:0]                         max_count_o
);

  localparam int AW = hla_pkg::ADDR_W;
  localparam int GW = hla_pkg::ANG_W;
  localparam int RW = hla_pkg::RHO_W;
  localparam int SW = hla_pkg::SPAN_W;
  localparam int CB = hla_pkg::COUNT_BITS;
  localparam logic [AW-1:0] ANGLES_A   = AW'(hla_pkg::ANGLES);
  localparam logic [AW-1:0] LAST_CELL  = AW'(hla_pkg::CELLS - 1);
  localparam logic [GW-1:0] LAST_ANGLE = GW'(hla_pkg::ANGLES - 1);
  localparam logic [SW-1:0] LAST_SPAN  = SW'(hla_pkg::PEAK_SPAN - 1);
  localparam logic [CB-1:0] COUNT_MAX  = '1;

  // config registers
  logic [12:0] width_q, height_q;
  logic [7:0]  thresh_q, margin_q;
  logic [16:0] offset_q;
  logic [19:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      thresh_q <= 8'd100;
      margin_q <= 8'd10;
      offset_q <= 17'd12800;
      scale_q  <= 20'd167772;
    end else if (cfg_we_i) begin
      case (hla_pkg::hla_cfg_e'(cfg_addr_i))
        hla_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg_wdata_i[12:0];
        hla_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg_wdata_i[12:0];
        hla_pkg::CFG_EDGE_THRESHOLD: thresh_q <= cfg_wdata_i[7:0];
        hla_pkg::CFG_BORDER_MARGIN:  margin_q <= cfg_wdata_i[7:0];
        hla_pkg::CFG_RHO_OFFSET:     offset_q <= cfg_wdata_i[16:0];
        hla_pkg::CFG_RHO_SCALE:      scale_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // item registers
  logic [11:0] x_q, y_q;
  logic [7:0]  str_q, r_q, a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= pixel_x_i;
      y_q   <= pixel_y_i;
      str_q <= edge_strength_i;
      r_q   <= rho_index_i;
      a_q   <= angle_index_i;
    end
  end

  // border and threshold test
  logic signed [13:0] w_lim, h_lim;
  logic vote_ok;
  assign w_lim = $signed({1'b0, width_q}) - $signed({6'b0, margin_q});
  assign h_lim = $signed({1'b0, height_q}) - $signed({6'b0, margin_q});
  assign vote_ok = ({1'b0, x_q} >= {5'b0, margin_q}) && ($signed({2'b0, x_q}) < w_lim) &&
                   ({1'b0, y_q} >= {5'b0, margin_q}) && ($signed({2'b0, y_q}) < h_lim) &&
                   (str_q > thresh_q);

  // clear sweep
  logic [AW-1:0] clr_addr_q;
  logic          clr_last;
  assign clr_last = clr_addr_q == LAST_CELL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_addr_q <= '0;
    else if (cmd_i.clr_step) clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
  end

  // rho pipeline, one angle per cycle
  logic [GW-1:0] ang_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [GW-1:0] a1_q, a2_q, a3_q, a4_q, a5_q;
  logic signed [15:0] cos1_q, sin1_q;
  logic signed [28:0] px_q, py_q;
  logic signed [30:0] t_q;
  logic        neg4_q;
  logic [33:0] mlo_q, mhi_q;
  logic [RW-1:0] bin5_q;
  logic [AW-1:0] addr6_q, addr7_q;
  logic [48:0] acc_sum;
  logic [14:0] bin_raw;
  logic [RW-1:0] bin_d;
  logic vote_last;

  assign vote_last = ang_q == LAST_ANGLE;
  assign acc_sum   = {mhi_q, 14'b0} + {15'b0, mlo_q} + (49'd1 << 33);
  assign bin_raw   = acc_sum[48:34];

  always_comb begin
    if (neg4_q) bin_d = '0;
    else if (bin_raw > 15'(hla_pkg::RHO - 1)) bin_d = RW'(hla_pkg::RHO - 1);
    else bin_d = bin_raw[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0;
    end else begin
      if (cmd_i.vote_issue) ang_q <= vote_last ? '0 : ang_q + GW'(1);
      v1_q <= cmd_i.vote_issue;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= ang_q;
    cos1_q <= hla_pkg::COS_ROM[ang_q];
    sin1_q <= hla_pkg::SIN_ROM[ang_q];
    a2_q   <= a1_q;
    px_q   <= $signed({1'b0, x_q}) * cos1_q;
    py_q   <= $signed({1'b0, y_q}) * sin1_q;
    a3_q   <= a2_q;
    t_q    <= 31'(px_q) + 31'(py_q) + $signed({4'b0, offset_q, 10'b0});
    a4_q   <= a3_q;
    neg4_q <= t_q[30];
    mlo_q  <= t_q[13:0] * scale_q;
    mhi_q  <= t_q[27:14] * scale_q;
    a5_q   <= a4_q;
    bin5_q <= bin_d;
    addr6_q <= AW'(bin5_q) * ANGLES_A + AW'(a5_q);
    addr7_q <= addr6_q;
  end

  // query cell and window scan
  logic in_range;
  logic [AW-1:0] q_addr;
  logic [CB-1:0] v_q, max_q;
  logic [SW-1:0] sdr_q, sda_q;
  logic signed [RW+2:0] row;
  logic signed [GW+2:0] col;
  logic scan_inb, scan_last, sv_q, fail_q, peak_cand;
  logic [AW-1:0] scan_addr;

  assign in_range = ({1'b0, r_q} < 9'(hla_pkg::RHO)) && ({1'b0, a_q} < 9'(hla_pkg::ANGLES));
  assign q_addr   = AW'(r_q) * ANGLES_A + AW'(a_q);

  assign row = $signed((RW+3)'(r_q)) - $signed((RW+3)'(hla_pkg::PEAK_H)) +
               $signed((RW+3)'(sdr_q));
  assign col = $signed((GW+3)'(a_q)) - $signed((GW+3)'(hla_pkg::PEAK_H)) +
               $signed((GW+3)'(sda_q));
  assign scan_inb = (row >= 0) && (row < $signed((RW+3)'(hla_pkg::RHO))) &&
                    (col >= 0) && (col < $signed((GW+3)'(hla_pkg::ANGLES)));
  assign scan_addr = AW'(row[RW-1:0]) * ANGLES_A + AW'(col[GW-1:0]);
  assign scan_last = (sdr_q == LAST_SPAN) && (sda_q == LAST_SPAN);

  assign peak_cand = in_range && (v_q > (max_q >> 1)) &&
                     ({1'b0, r_q} >= 9'd1) && ({1'b0, r_q} <= 9'(hla_pkg::RHO - 2)) &&
                     ({1'b0, a_q} >= 9'd1) && ({1'b0, a_q} <= 9'(hla_pkg::ANGLES - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdr_q <= '0;
      sda_q <= '0;
      sv_q  <= 1'b0;
    end else begin
      sv_q <= cmd_i.scan_issue && scan_inb;
      if (cmd_i.scan_init) begin
        sdr_q <= '0;
        sda_q <= '0;
      end else if (cmd_i.scan_issue) begin
        if (sda_q == LAST_SPAN) begin
          sda_q <= '0;
          sdr_q <= sdr_q + SW'(1);
        end else begin
          sda_q <= sda_q + SW'(1);
        end
      end
    end
  end

  // accumulator memory: one write port, one registered read port
  logic [CB-1:0] mem_q [hla_pkg::CELLS];
  logic [CB-1:0] rdata_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CB-1:0] wr_data, inc;

  assign inc = (rdata_q == COUNT_MAX) ? rdata_q : rdata_q + CB'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr6_q;
    if (v6_q) begin
      rd_en = 1'b1;
    end else if (cmd_i.q_read) begin
      rd_en   = in_range;
      rd_addr = q_addr;
    end else if (cmd_i.scan_issue) begin
      rd_en   = scan_inb;
      rd_addr = scan_addr;
    end
  end

  always_comb begin
    wr_en   = cmd_i.clr_step || v7_q;
    wr_addr = cmd_i.clr_step ? clr_addr_q : addr7_q;
    wr_data = cmd_i.clr_step ? '0 : inc;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // running maximum and window compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= CB'(1);
      fail_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step && clr_last) max_q <= CB'(1);
      else if (v7_q && (inc > max_q)) max_q <= inc;
      if (cmd_i.scan_init) fail_q <= 1'b0;
      else if (sv_q && (rdata_q > v_q)) fail_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_latch) v_q <= in_range ? rdata_q : '0;
  end

  // intensity = count*255/max
  logic [23:0] quotient;
  logic        div_done;

  hla_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (24'(v_q) * 24'd255),
    .divisor_i  (max_q),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // result register
  logic        ov_q;
  logic [15:0] cnt_o_q, max_o_q;
  logic [7:0]  int_o_q;
  logic        pk_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.out_load) ov_q <= 1'b1;
    else if (out_ready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cnt_o_q <= v_q;
      int_o_q <= quotient[7:0];
      pk_o_q  <= peak_cand && !fail_q;
      max_o_q <= max_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign cell_count_o = cnt_o_q;
  assign intensity_o  = int_o_q;
  assign is_peak_o    = pk_o_q;
  assign max_count_o  = max_o_q;

  assign status_o.clr_last  = clr_last;
  assign status_o.vote_ok   = vote_ok;
  assign status_o.vote_last = vote_last;
  assign status_o.pipe_busy = v1_q || v2_q || v3_q || v4_q || v5_q || v6_q || v7_q;
  assign status_o.peak_cand = peak_cand;
  assign status_o.scan_last = scan_last;
  assign status_o.div_done  = div_done;
  assign status_o.out_free  = !ov_q || out_ready_i;

`ifndef SYNTH
  a_max_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni) max_q != '0)
    else $error("running maximum dropped to zero");
  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clr_step && v7_q))
    else $error("clear sweep collides with vote write-back");
  a_max_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(cmd_i.clr_step) |-> max_q >= $past(max_q))
    else $error("running maximum decreased outside a clear");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !status_o.pipe_busy && !sv_q)
    else $error("new item loaded while work still in flight");
`endif

endmodule

[sv/hla_ctrl.sv]
// Sequencer for clear, vote and query items.
module hla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           action_i,
  output logic                 in_ready_o,
  input  hla_pkg::hla_status_t status_i,
  output hla_pkg::hla_cmd_t    cmd_o
);

  hla_pkg::hla_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hla_pkg::ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      hla_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = hla_pkg::ST_IDLE;
      end
      hla_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (hla_pkg::hla_action_e'(action_i))
            hla_pkg::ACT_VOTE:  state_d = hla_pkg::ST_VCHECK;
            hla_pkg::ACT_QUERY: state_d = hla_pkg::ST_QREAD;
            hla_pkg::ACT_CLEAR: state_d = hla_pkg::ST_CLEAR;
            default:            state_d = hla_pkg::ST_IDLE;
          endcase
        end
      end
      hla_pkg::ST_VCHECK:
        state_d = status_i.vote_ok ? hla_pkg::ST_VOTE : hla_pkg::ST_IDLE;
      hla_pkg::ST_VOTE: begin
        cmd_o.vote_issue = 1'b1;
        if (status_i.vote_last) state_d = hla_pkg::ST_VDRAIN;
      end
      hla_pkg::ST_VDRAIN:
        if (!status_i.pipe_busy) state_d = hla_pkg::ST_IDLE;
      hla_pkg::ST_QREAD: begin
        cmd_o.q_read = 1'b1;
        state_d = hla_pkg::ST_QLATCH;
      end
      hla_pkg::ST_QLATCH: begin
        cmd_o.q_latch = 1'b1;
        state_d = hla_pkg::ST_QDECIDE;
      end
      hla_pkg::ST_QDECIDE: begin
        if (status_i.peak_cand) begin
          cmd_o.scan_init = 1'b1;
          state_d = hla_pkg::ST_SCAN;
        end else begin
          state_d = hla_pkg::ST_DIV;
        end
      end
      hla_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) state_d = hla_pkg::ST_SDRAIN;
      end
      hla_pkg::ST_SDRAIN: state_d = hla_pkg::ST_DIV;
      hla_pkg::ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = hla_pkg::ST_DWAIT;
      end
      hla_pkg::ST_DWAIT:
        if (status_i.div_done) state_d = hla_pkg::ST_OUT;
      hla_pkg::ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = hla_pkg::ST_IDLE;
        end
      end
      default: state_d = hla_pkg::ST_IDLE;
    endcase
  end

endmodule

[sv/hough_line_accumulator_core.sv]
// Top level of the Hough line accumulator: controller plus datapath.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, action_i, pixel_*, edge_, | in
//          | rho_index_i, angle_index_i                       |
//  out     | out_valid_o/out_ready_i, cell_count_o,           | out
//          | intensity_o, is_peak_o, max_count_o              |
//  cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i (write only)   | in
//
// Vote beat: each angle is issued through a 7-stage rho pipeline into one
//   read-modify-write of the accumulator RAM per cycle.
// Query beat: a cell read, plus the 18x18 window scan when the cell is
//   a peak candidate, plus the serial divider (intensity).
// Clear beat and reset: a sweep over all 46080 RAM words, one word per cycle,
//   with in_ready_o low; config writes are still taken.
// One item at a time; a finished result sits in the output register, so the
//   next beat is accepted while out_ready_i is low.
module hough_line_accumulator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [11:0]                    pixel_x_i,
  input  logic [11:0]                    pixel_y_i,
  input  logic [7:0]                     edge_strength_i,
  input  logic [7:0]                     rho_index_i,
  input  logic [7:0]                     angle_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [15:0]                    cell_count_o,
  output logic [7:0]                     intensity_o,
  output logic                           is_peak_o,
  output logic [15:0]                    max_count_o,
  input  logic                           cfg_we_i,
  input  logic [hla_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [hla_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  hla_pkg::hla_cmd_t    cmd;
  hla_pkg::hla_status_t status;

  // controller: state machine only, talks to the datapath through cmd/status
  hla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: config, RAM, rho pipeline, scan, divider, result register
  hla_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .edge_strength_i (edge_strength_i),
    .rho_index_i     (rho_index_i),
    .angle_index_i   (angle_index_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .cell_count_o    (cell_count_o),
    .intensity_o     (intensity_o),
    .is_peak_o       (is_peak_o),
    .max_count_o     (max_count_o)
  );

endmodule
